>>> rtl/core/mgsr_pkg.sv
// Shared widths, constants, codes and types of the median gas sensor ratio block
`default_nettype none

package mgsr_pkg;

    // Default sizes handed to the top level parameters
    localparam int WINDOW_DEF        = 9;
    localparam int CALIB_WINDOWS_DEF = 16;

    // Field and datapath widths
    localparam int SAMPLE_W   = 12;
    localparam int GAIN_W     = 16;
    localparam int SUPPLY_W   = 25;
    localparam int LOAD_W     = 20;
    localparam int R0_W       = 24;
    localparam int RS_W       = 24;
    localparam int RATIO_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int V_W        = SAMPLE_W + GAIN_W;
    localparam int SUM_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // Divider operand widths: load times supply headroom over a voltage
    localparam int DIV_DVD_W = LOAD_W + SUPPLY_W;
    localparam int DIV_DVS_W = V_W;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_R0_PRESET = 3'd4;

    // Register reset values
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd1612;
    localparam logic [SUPPLY_W-1:0] SUPPLY_RST = 25'd5000000;
    localparam logic [LOAD_W-1:0]   LOAD_RST   = 20'd1000;

    // Special values of the resistance calculation
    localparam logic [V_W-1:0]  LOW_UV_LIMIT = 28'd1000;
    localparam logic [RS_W-1:0] LOW_UV_RS    = 24'd9999000;
    localparam logic [RS_W-1:0] RS_MAX       = 24'hFFFFFF;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_RATIO_OK   = 2'd0,
        ST_NO_REF     = 2'd1,
        ST_CALIB_DONE = 2'd2
    } status_t;

    // Configuration register file contents
    typedef struct packed {
        logic                mode;
        logic [GAIN_W-1:0]   sense_gain_uv;
        logic [SUPPLY_W-1:0] supply_uv;
        logic [LOAD_W-1:0]   load_ohm;
        logic [R0_W-1:0]     r0_preset_ohm;
    } cfg_t;

    // Window sorter status
    typedef struct packed {
        logic                last;
        logic [SAMPLE_W-1:0] median;
    } sort_st_t;

    // Divider request and response
    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/mgsr_in_if.sv
// Sample channel: valid/ready handshake carrying one ADC sample
`default_nettype none

interface mgsr_in_if;
    import mgsr_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mgsr_out_if.sv
// Result channel: valid/ready handshake carrying one window result
`default_nettype none

interface mgsr_out_if;
    import mgsr_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] median_raw;
    logic [RS_W-1:0]     rs_ohm;
    logic [RATIO_W-1:0]  ratio_q16;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output median_raw, output rs_ohm, output ratio_q16,
                    output status, input ready);
    modport sink   (input valid, input median_raw, input rs_ohm, input ratio_q16,
                    input status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mgsr_sort.sv
// Window store kept in ascending order by insertion, one sample per cycle
`default_nettype none

module mgsr_sort #(
    parameter int WINDOW = 9
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          insert,
    input  wire logic [mgsr_pkg::SAMPLE_W-1:0] sample,
    output mgsr_pkg::sort_st_t                 st
);
    import mgsr_pkg::*;

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int MID    = WINDOW / 2;

    logic [FILL_W-1:0]   fill_reg;
    logic [SAMPLE_W-1:0] sorted_reg [WINDOW];
    logic [WINDOW-1:0]   big;

    // Entries past the fill point count as larger than any sample
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            big[i] = (FILL_W'(i) >= fill_reg) || (sorted_reg[i] > sample);
        end
    end

    // Shift larger entries up one place, drop the sample into the gap
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (insert && big[0])
                begin
                    sorted_reg[0] <= sample;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (insert && big[i])
                begin
                    sorted_reg[i] <= big[i-1] ? sorted_reg[i-1] : sample;
                end
            end
        end
    end

    // Fill count, back to zero when the window completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (insert)
        begin
            fill_reg <= st.last ? '0 : fill_reg + 1'b1;
        end
    end

    assign st.last   = (fill_reg == FILL_W'(WINDOW - 1));
    assign st.median = sorted_reg[MID];

endmodule

`default_nettype wire

>>> rtl/core/mgsr_div.sv
// Restoring divider, one quotient bit per cycle
`default_nettype none

module mgsr_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  mgsr_pkg::div_req_t      req,
    output mgsr_pkg::div_rsp_t      rsp
);
    import mgsr_pkg::*;

    localparam int CNT_W = $clog2(DIV_DVD_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DVD_W-1:0] quo_reg;
    logic [DIV_DVS_W-1:0] rem_reg;
    logic [DIV_DVS_W-1:0] dvs_reg;

    logic [DIV_DVS_W:0]   shifted;
    logic [DIV_DVS_W:0]   diff;
    logic                 ge;

    // One trial subtract per step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_DVD_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = (shifted >= {1'b0, dvs_reg});
    end

    // Control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DIV_DVS_W-1:0] : shifted[DIV_DVS_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/core/mgsr_ctrl.sv
// Sequencer: voltage, resistance, calibration mean and ratio over the shared divider
`default_nettype none

module mgsr_ctrl #(
    parameter int CALIB_WINDOWS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  mgsr_pkg::cfg_t                     cfg,
    input  wire logic                          mode_wr,
    mgsr_in_if.sink                            sample_ch,
    mgsr_out_if.source                         result_ch,
    input  mgsr_pkg::sort_st_t                 sort_st,
    output logic                               insert,
    output mgsr_pkg::div_req_t                 div_req,
    input  mgsr_pkg::div_rsp_t                 div_rsp
);
    import mgsr_pkg::*;

    localparam int CW_W = $clog2(CALIB_WINDOWS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MED,
        S_VOLT,
        S_CHK,
        S_PROD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_POST,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_RS,
        OP_MEAN,
        OP_RATIO
    } div_op_t;

    state_t state_reg;
    div_op_t op_reg;
    logic   out_valid_reg;

    logic [SUM_W-1:0] calib_sum_reg;
    logic [CW_W-1:0]  calib_cnt_reg;
    logic [R0_W-1:0]  learned_r0_reg;
    logic             learned_valid_reg;

    logic [SAMPLE_W-1:0]  med_reg;
    logic [V_W-1:0]       v_reg;
    logic [SUPPLY_W-1:0]  diff_reg;
    logic [RS_W-1:0]      rs_reg;
    logic [DIV_DVD_W-1:0] dvd_reg;
    logic [DIV_DVS_W-1:0] dvs_reg;
    logic [RS_W-1:0]      res_rs_reg;
    logic [RATIO_W-1:0]   res_ratio_reg;
    status_t              res_status_reg;

    logic [SAMPLE_W-1:0]  out_median_reg;
    logic [RS_W-1:0]      out_rs_reg;
    logic [RATIO_W-1:0]   out_ratio_reg;
    status_t              out_status_reg;

    logic [SUM_W-1:0]     sum_next;
    logic [R0_W-1:0]      r0_sel;
    logic [RS_W-1:0]      q_rs;
    logic [RATIO_W-1:0]   q_ratio;
    logic                 calib_last;
    logic                 out_load;

    // Combinational helpers
    always_comb
    begin
        sum_next   = calib_sum_reg + SUM_W'(rs_reg);
        r0_sel     = learned_valid_reg ? learned_r0_reg : cfg.r0_preset_ohm;
        q_rs       = (|div_rsp.quotient[DIV_DVD_W-1:RS_W]) ? RS_MAX
                                                           : div_rsp.quotient[RS_W-1:0];
        q_ratio    = (|div_rsp.quotient[DIV_DVD_W-1:RATIO_W]) ? '1
                                                              : div_rsp.quotient[RATIO_W-1:0];
        calib_last = (calib_cnt_reg == CW_W'(CALIB_WINDOWS - 1));
        out_load   = (state_reg == S_OUT) && (!out_valid_reg || result_ch.ready);
    end

    assign insert          = sample_ch.valid && sample_ch.ready;
    assign sample_ch.ready = (state_reg == S_IDLE);

    assign div_req.start    = (state_reg == S_DIV_GO);
    assign div_req.dividend = dvd_reg;
    assign div_req.divisor  = dvs_reg;

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.median_raw = out_median_reg;
    assign result_ch.rs_ohm     = out_rs_reg;
    assign result_ch.ratio_q16  = out_ratio_reg;
    assign result_ch.status     = out_status_reg;

    // State machine, calibration state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            op_reg            <= OP_RS;
            out_valid_reg     <= 1'b0;
            calib_sum_reg     <= '0;
            calib_cnt_reg     <= '0;
            learned_r0_reg    <= '0;
            learned_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (mode_wr)
            begin
                calib_sum_reg <= '0;
                calib_cnt_reg <= '0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (insert && sort_st.last)
                    begin
                        state_reg <= S_MED;
                    end
                end
                S_MED:
                begin
                    state_reg <= S_VOLT;
                end
                S_VOLT:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if ((v_reg <= LOW_UV_LIMIT) || (V_W'(cfg.supply_uv) <= v_reg))
                    begin
                        state_reg <= S_POST;
                    end
                    else
                    begin
                        state_reg <= S_PROD;
                    end
                end
                S_PROD:
                begin
                    op_reg    <= OP_RS;
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        unique case (op_reg)
                            OP_RS:
                            begin
                                state_reg <= S_POST;
                            end
                            OP_MEAN:
                            begin
                                learned_r0_reg    <= q_rs;
                                learned_valid_reg <= 1'b1;
                                calib_sum_reg     <= '0;
                                calib_cnt_reg     <= '0;
                                state_reg         <= S_OUT;
                            end
                            OP_RATIO:
                            begin
                                state_reg <= S_OUT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_POST:
                begin
                    if (cfg.mode)
                    begin
                        calib_sum_reg <= sum_next;
                        if (calib_last)
                        begin
                            op_reg    <= OP_MEAN;
                            state_reg <= S_DIV_GO;
                        end
                        else
                        begin
                            calib_cnt_reg <= calib_cnt_reg + 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else if (r0_sel == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        op_reg    <= OP_RATIO;
                        state_reg <= S_DIV_GO;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_MED:
            begin
                med_reg <= sort_st.median;
            end
            S_VOLT:
            begin
                v_reg <= V_W'(med_reg) * V_W'(cfg.sense_gain_uv);
            end
            S_CHK:
            begin
                // Low voltage and over-supply short cuts
                if (v_reg <= LOW_UV_LIMIT)
                begin
                    rs_reg <= LOW_UV_RS;
                end
                else if (V_W'(cfg.supply_uv) <= v_reg)
                begin
                    rs_reg <= '0;
                end
                diff_reg <= cfg.supply_uv - v_reg[SUPPLY_W-1:0];
            end
            S_PROD:
            begin
                dvd_reg <= DIV_DVD_W'(cfg.load_ohm) * DIV_DVD_W'(diff_reg);
                dvs_reg <= v_reg;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    unique case (op_reg)
                        OP_RS:
                        begin
                            rs_reg <= q_rs;
                        end
                        OP_MEAN:
                        begin
                            res_rs_reg     <= q_rs;
                            res_ratio_reg  <= '0;
                            res_status_reg <= ST_CALIB_DONE;
                        end
                        OP_RATIO:
                        begin
                            res_rs_reg     <= rs_reg;
                            res_ratio_reg  <= q_ratio;
                            res_status_reg <= ST_RATIO_OK;
                        end
                        default:
                        begin
                            res_status_reg <= ST_RATIO_OK;
                        end
                    endcase
                end
            end
            S_POST:
            begin
                if (cfg.mode)
                begin
                    dvd_reg <= DIV_DVD_W'(sum_next);
                    dvs_reg <= DIV_DVS_W'(CALIB_WINDOWS);
                end
                else
                begin
                    dvd_reg        <= DIV_DVD_W'({rs_reg, 16'h0000});
                    dvs_reg        <= DIV_DVS_W'(r0_sel);
                    res_rs_reg     <= rs_reg;
                    res_ratio_reg  <= '0;
                    res_status_reg <= ST_NO_REF;
                end
            end
            default:
            begin
            end
        endcase

        // Output register
        if (out_load)
        begin
            out_median_reg <= med_reg;
            out_rs_reg     <= res_rs_reg;
            out_ratio_reg  <= res_ratio_reg;
            out_status_reg <= res_status_reg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/median_gas_sensor_ratio_top.sv
// Top level of the median gas sensor ratio block: register file and unit wiring
//
// Usage:
//   sample_ch takes one 12-bit ADC sample per item; result_ch gives one item per
//   finished window (none for calibrate-mode windows that do not end the set).
//   Registers are written through cfg_we / cfg_index / cfg_data by the user while
//   idle, not checked by the block. Writing mode clears calibration sum and count.
// Timing:
//   A sample that does not end a window is taken and leaves the block idle. The sample that
//   ends a window starts the sequence: median, voltage multiply, load multiply,
//   then up to two passes of the 45-step restoring divider (resistance, then
//   ratio or calibration mean). A voltage outside the divider range skips the
//   load multiply and the resistance pass. sample_ch.ready stays low until the
//   block is idle again.
// Reset:
//   rst_n clears fill count, calibration state, learned reference and the
//   result valid, and loads the register defaults.
// Stall:
//   A result waits in the output register while result_ch.ready is low; new
//   samples are still taken, and a later window waits before its result is
//   written.
`default_nettype none

module median_gas_sensor_ratio_top #(
    parameter int WINDOW        = mgsr_pkg::WINDOW_DEF,
    parameter int CALIB_WINDOWS = mgsr_pkg::CALIB_WINDOWS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [mgsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mgsr_pkg::CFG_DATA_W-1:0] cfg_data,
    mgsr_in_if.sink                              sample_ch,
    mgsr_out_if.source                           result_ch
);
    import mgsr_pkg::*;

    cfg_t      cfg_reg;
    logic      mode_wr;
    logic      insert;
    sort_st_t  sort_st;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    assign mode_wr = cfg_we && (cfg_index == REG_MODE);

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= 1'b0;
            cfg_reg.sense_gain_uv <= GAIN_RST;
            cfg_reg.supply_uv     <= SUPPLY_RST;
            cfg_reg.load_ohm      <= LOAD_RST;
            cfg_reg.r0_preset_ohm <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:      cfg_reg.mode          <= cfg_data[0];
                REG_GAIN:      cfg_reg.sense_gain_uv <= cfg_data[GAIN_W-1:0];
                REG_SUPPLY:    cfg_reg.supply_uv     <= cfg_data[SUPPLY_W-1:0];
                REG_LOAD:      cfg_reg.load_ohm      <= cfg_data[LOAD_W-1:0];
                REG_R0_PRESET: cfg_reg.r0_preset_ohm <= cfg_data[R0_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mgsr_sort #(
        .WINDOW (WINDOW)
    ) u_sort (
        .clk    (clk),
        .rst_n  (rst_n),
        .insert (insert),
        .sample (sample_ch.sample),
        .st     (sort_st)
    );

    mgsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mgsr_ctrl #(
        .CALIB_WINDOWS (CALIB_WINDOWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mode_wr   (mode_wr),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .sort_st   (sort_st),
        .insert    (insert),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

endmodule

`default_nettype wire
